// ----- hw/rtl/sntg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sntg_pkg
// Shared types and constants of the square and noise tone generator.
// ----------------------------------------------------------------------------
package sntg_pkg;

    // Action codes carried by the input word.
    localparam logic ACT_QUEUE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [15:0] MASTER_RESET = 16'd14418;
    localparam logic [31:0] NOISE_SEED   = 32'd2463534242;
    localparam logic [23:0] ONE_SAMPLE   = 24'd256;
    localparam logic [8:0]  FULL_VOLUME  = 9'd256;

    // Widths of the serial arithmetic units.
    localparam int MUL_W   = 16;
    localparam int DIV_N_W = 32;
    localparam int DIV_D_W = 16;

    typedef struct packed {
        logic        action;
        logic [23:0] tone_period;
        logic [15:0] tone_length;
        logic [8:0]  tone_volume;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               playing;
        logic               last_sample;
        logic               tone_dropped;
    } t_out_word;

    typedef struct packed {
        logic [23:0] period;
        logic [15:0] length;
        logic [8:0]  volume;
    } t_tone_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCALE,
        S_PROD_GO,
        S_PROD,
        S_DIV,
        S_DONE
    } t_state;

endpackage : sntg_pkg
`default_nettype wire

// ----- hw/rtl/sntg_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sntg_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sntg_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sntg_pkg::MUL_W-1:0]    i_a,
    input  wire logic [sntg_pkg::MUL_W-1:0]    i_b,
    output logic                               o_done,
    output logic [2*sntg_pkg::MUL_W-1:0]       o_product
);

    localparam int CNT_W = $clog2(sntg_pkg::MUL_W);

    logic                        r_run;
    logic [CNT_W-1:0]            r_count;
    logic                        r_done;
    logic [sntg_pkg::MUL_W-1:0]  r_a;
    logic [sntg_pkg::MUL_W-1:0]  r_hi;
    logic [sntg_pkg::MUL_W-1:0]  r_lo;
    logic [sntg_pkg::MUL_W:0]    sum;

    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_count <= '0;
            end else if (r_run) begin
                r_count <= r_count + 1'b1;
                if (r_count == CNT_W'(sntg_pkg::MUL_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_run) begin
            r_hi <= sum[sntg_pkg::MUL_W:1];
            r_lo <= {sum[0], r_lo[sntg_pkg::MUL_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule : sntg_mul
`default_nettype wire

// ----- hw/rtl/sntg_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sntg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sntg_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sntg_pkg::DIV_N_W-1:0]  i_dividend,
    input  wire logic [sntg_pkg::DIV_D_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [sntg_pkg::DIV_N_W-1:0]       o_quotient
);

    localparam int CNT_W = $clog2(sntg_pkg::DIV_N_W);

    logic                          r_run;
    logic [CNT_W-1:0]              r_count;
    logic                          r_done;
    logic [sntg_pkg::DIV_D_W-1:0]  r_div;
    logic [sntg_pkg::DIV_D_W-1:0]  r_rem;
    logic [sntg_pkg::DIV_N_W-1:0]  r_dq;
    logic [sntg_pkg::DIV_D_W:0]    shifted;
    logic [sntg_pkg::DIV_D_W:0]    diff;
    logic                          ge;

    // The partial remainder with the next dividend bit shifted in.
    assign shifted = {r_rem, r_dq[sntg_pkg::DIV_N_W-1]};
    assign ge      = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_count <= '0;
            end else if (r_run) begin
                r_count <= r_count + 1'b1;
                if (r_count == CNT_W'(sntg_pkg::DIV_N_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_dq  <= i_dividend;
        end else if (r_run) begin
            r_rem <= ge ? diff[sntg_pkg::DIV_D_W-1:0] : shifted[sntg_pkg::DIV_D_W-1:0];
            r_dq  <= {r_dq[sntg_pkg::DIV_N_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule : sntg_div
`default_nettype wire

// ----- hw/rtl/sntg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sntg_queue
// Circular queue of tone entries with a registered read of the head entry.
// ----------------------------------------------------------------------------
module sntg_queue #(
    parameter int DEPTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire sntg_pkg::t_tone_entry i_push_entry,
    input  wire logic                  i_pop,
    output sntg_pkg::t_queue_status    o_status,
    output sntg_pkg::t_tone_entry      o_head_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sntg_pkg::t_tone_entry r_mem [0:DEPTH-1];
    sntg_pkg::t_tone_entry r_rd_data;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [CW-1:0]         r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_entry;
        end
        r_rd_data <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head_entry   = r_rd_data;

endmodule : sntg_queue
`default_nettype wire

// ----- hw/rtl/square_noise_tone_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Timing: a queue word takes effect at its accept edge and gives no result. A tick
// with no tone to play goes straight to the result state; one that plays on first runs
// the serial multiplier and divider, and one that starts a tone also scales its volume.
// Throughput: one tick at a time; queue words are taken every cycle while idle.
// Reset (synchronous, active low) empties the queue, stops playback, reseeds the
// noise register and restores the default master level.
// ----------------------------------------------------------------------------
// square_noise_tone_generator
// Queues tone descriptors and plays them back to back as square waves or
// xorshift noise with a linear decay, one signed sample word per tick.
// ----------------------------------------------------------------------------
module square_noise_tone_generator #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input channel.
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire sntg_pkg::t_in_word  i_in_word,
    // Output channel.
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output sntg_pkg::t_out_word      o_out_word,
    // Master level register.
    input  wire logic                i_cfg_wr_en,
    input  wire logic [15:0]         i_cfg_wr_data
);

    // ------------------------------------------------------------------
    // Control state.
    // ------------------------------------------------------------------
    sntg_pkg::t_state        r_state;
    sntg_pkg::t_state        n_state;
    logic [15:0]             r_master;
    logic                    r_busy;
    logic                    r_drop;
    logic                    r_out_valid;
    sntg_pkg::t_out_word     r_out_word;

    // Current tone.
    logic [23:0]             r_period;
    logic [15:0]             r_length;
    logic [15:0]             r_index;
    logic [14:0]             r_scale;
    logic [23:0]             r_phase;
    logic [31:0]             r_noise;
    logic [14:0]             r_mag;

    // Unit control.
    logic                    in_accept;
    logic                    out_free;
    logic                    q_push;
    logic                    q_pop;
    sntg_pkg::t_tone_entry   q_push_entry;
    sntg_pkg::t_tone_entry   q_head;
    sntg_pkg::t_queue_status q_status;
    logic                    mul_start;
    logic [15:0]             mul_a;
    logic [15:0]             mul_b;
    logic                    mul_done;
    logic [31:0]             mul_product;
    logic                    div_start;
    logic                    div_done;
    logic [31:0]             div_quotient;

    // Datapath helpers.
    logic [24:0]             vol_master;
    logic [39:0]             scale_full;
    logic [23:0]             head_period;
    logic [31:0]             noise_a;
    logic [31:0]             noise_b;
    logic [31:0]             noise_next;
    logic [24:0]             phase_step;
    logic [24:0]             phase_next;
    logic                    positive;
    logic [15:0]             mag_ext;
    logic [15:0]             index_next;
    logic                    tone_over;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != sntg_pkg::S_IDLE);

    // ------------------------------------------------------------------
    // Tone queue. A start with zero length is ignored; a start that
    // finds the queue full is dropped and raises the sticky drop flag.
    // ------------------------------------------------------------------
    assign q_push = in_accept && (i_in_word.action == sntg_pkg::ACT_QUEUE)
                    && (i_in_word.tone_length != '0) && !q_status.full;
    assign q_pop  = (r_state == sntg_pkg::S_LOAD);

    assign q_push_entry.period = i_in_word.tone_period;
    assign q_push_entry.length = i_in_word.tone_length;
    assign q_push_entry.volume = (i_in_word.tone_volume > sntg_pkg::FULL_VOLUME)
                                 ? sntg_pkg::FULL_VOLUME : i_in_word.tone_volume;

    sntg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_entry (q_push_entry),
        .i_pop        (q_pop),
        .o_status     (q_status),
        .o_head_entry (q_head)
    );

    // ------------------------------------------------------------------
    // Shared serial multiplier. At tone start it forms volume times the
    // master level; on every playing tick it forms scale times the
    // remaining length, which the divider then divides by the length.
    // ------------------------------------------------------------------
    assign mul_a = (r_state == sntg_pkg::S_LOAD) ? r_master : {1'b0, r_scale};
    assign mul_b = (r_state == sntg_pkg::S_LOAD) ? {7'd0, q_head.volume}
                                                 : (r_length - r_index);

    sntg_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    sntg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_product),
        .i_divisor  (r_length),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Scale is volume * master * 32767 >> 24, with 32767 done as a
    // shift by 15 and a subtract.
    assign vol_master = mul_product[24:0];
    assign scale_full = {vol_master, 15'd0} - {15'd0, vol_master};

    // A period below one sample is raised to one sample; zero stays noise.
    assign head_period = (q_head.period != '0 && q_head.period < sntg_pkg::ONE_SAMPLE)
                         ? sntg_pkg::ONE_SAMPLE : q_head.period;

    // ------------------------------------------------------------------
    // Waveform. The square wave is positive while twice the phase is
    // below the period; noise steps the xorshift register and takes
    // its bit 16 as the sign.
    // ------------------------------------------------------------------
    assign noise_a    = r_noise ^ (r_noise << 13);
    assign noise_b    = noise_a ^ (noise_a >> 17);
    assign noise_next = noise_b ^ (noise_b << 5);

    assign phase_step = {1'b0, r_phase} + {1'b0, sntg_pkg::ONE_SAMPLE};
    assign phase_next = (phase_step >= {1'b0, r_period})
                        ? phase_step - {1'b0, r_period} : phase_step;

    assign positive   = (r_period != '0) ? ({r_phase, 1'b0} < {1'b0, r_period})
                                         : noise_next[16];
    assign mag_ext    = {1'b0, r_mag};
    assign index_next = r_index + 1'b1;
    assign tone_over  = (index_next >= r_length);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            sntg_pkg::S_IDLE: begin
                if (in_accept && i_in_word.action == sntg_pkg::ACT_TICK) begin
                    if (!r_busy && !q_status.empty) begin
                        n_state = sntg_pkg::S_LOAD;
                    end else if (r_busy) begin
                        n_state = sntg_pkg::S_PROD_GO;
                    end else begin
                        n_state = sntg_pkg::S_DONE;
                    end
                end
            end
            sntg_pkg::S_LOAD: begin
                mul_start = 1'b1;
                n_state   = sntg_pkg::S_SCALE;
            end
            sntg_pkg::S_SCALE: begin
                if (mul_done) begin
                    n_state = sntg_pkg::S_PROD_GO;
                end
            end
            sntg_pkg::S_PROD_GO: begin
                mul_start = 1'b1;
                n_state   = sntg_pkg::S_PROD;
            end
            sntg_pkg::S_PROD: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = sntg_pkg::S_DIV;
                end
            end
            sntg_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = sntg_pkg::S_DONE;
                end
            end
            sntg_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = sntg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sntg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sntg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Control and tone state. All per-sample updates are committed in
    // the cycle the result word is loaded into the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master    <= sntg_pkg::MASTER_RESET;
            r_busy      <= 1'b0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= '0;
            r_length    <= '0;
            r_index     <= '0;
            r_scale     <= '0;
            r_phase     <= '0;
            r_noise     <= sntg_pkg::NOISE_SEED;
        end else begin
            if (i_cfg_wr_en) begin
                r_master <= i_cfg_wr_data;
            end
            // In the result state a taken word is replaced below.
            if (r_out_valid && !i_out_stall && r_state != sntg_pkg::S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept && i_in_word.action == sntg_pkg::ACT_QUEUE
                && i_in_word.tone_length != '0 && q_status.full) begin
                r_drop <= 1'b1;
            end
            if (r_state == sntg_pkg::S_LOAD) begin
                r_period <= head_period;
                r_length <= q_head.length;
                r_index  <= '0;
                r_phase  <= '0;
                r_busy   <= 1'b1;
            end
            if (r_state == sntg_pkg::S_SCALE && mul_done) begin
                r_scale <= scale_full[38:24];
            end
            if (r_state == sntg_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_drop      <= 1'b0;
                if (r_busy) begin
                    if (r_period != '0) begin
                        r_phase <= phase_next[23:0];
                    end else begin
                        r_noise <= noise_next;
                    end
                    r_index <= index_next;
                    if (tone_over) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == sntg_pkg::S_DIV && div_done) begin
            r_mag <= div_quotient[14:0];
        end
        if (r_state == sntg_pkg::S_DONE && out_free) begin
            r_out_word.sample       <= r_busy ? (positive ? mag_ext : 16'd0 - mag_ext)
                                              : 16'd0;
            r_out_word.playing      <= r_busy;
            r_out_word.last_sample  <= r_busy && tone_over && q_status.empty;
            r_out_word.tone_dropped <= r_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule : square_noise_tone_generator
`default_nettype wire

// ----- hw/rtl/sntg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sntg_checker
// Port-level checks of the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module sntg_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                o_in_stall,
    input  wire sntg_pkg::t_in_word  i_in_word,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_stall,
    input  wire sntg_pkg::t_out_word o_out_word,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [15:0]         i_cfg_wr_data
);

    // A word held back by the receiver stays offered.
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word withdrawn while stalled");

    // A word held back by the receiver does not change.
    a_out_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // A tick keeps the block busy for at least the following cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.action == sntg_pkg::ACT_TICK
        |=> o_in_stall)
        else $error("tick accepted without entering its computation");

    // An idle sample is silent and never marks the end of a tone.
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.playing
        |-> o_out_word.sample == 16'sd0 && !o_out_word.last_sample)
        else $error("idle sample is not silent");

    // The decayed magnitude never exceeds full scale.
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.sample != 16'h8000)
        else $error("sample magnitude beyond full scale");

endmodule : sntg_checker

bind square_noise_tone_generator sntg_checker u_sntg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_in_word     (i_in_word),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_word    (o_out_word),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data)
);
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the square and noise tone generator. A behavioral
// predictor follows every accepted word and queues the expected sample words.
// A checker compares them with what the block returns. Directed tests are
// followed by random traffic under several master levels and idling patterns, then by more directed tests.
// ----------------------------------------------------------------------------
module tb;

    localparam int          QUEUE_DEPTH    = 8;
    localparam logic [31:0] FULL_SCALE     = 32'd32767;
    localparam int          WATCHDOG_LIMIT = 5000;
    // Settling time after the drain, before a master level write.
    localparam int          SETTLE_CYCLES  = 100;
    localparam int          END_CYCLES     = 150;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          REPORT_LIMIT   = 10;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    sntg_pkg::t_in_word  in_word = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    sntg_pkg::t_out_word out_word;
    logic                cfg_wr_en = 1'b0;
    logic [15:0]         cfg_wr_data = '0;

    // Idling controls, set per phase by the test tasks.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off: the test raises hold_requests, the stall
    // process notices the change and counts the hold itself.
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    int mismatch_count = 0;
    int words_checked = 0;
    int idle_cycles = 0;

    // Sample words the block still owes us, oldest first.
    sntg_pkg::t_out_word expected_words[$];

    // Predictor state, reset values as after the block's reset.
    sntg_pkg::t_tone_entry pending_tones[$];
    logic        tone_active = 1'b0;
    logic [23:0] tone_period_now = '0;
    logic [15:0] tone_length_now = '0;
    logic [15:0] tone_pos = '0;
    logic [14:0] tone_scale = '0;
    logic [31:0] phase_acc = '0;
    logic [31:0] noise_state = sntg_pkg::NOISE_SEED;
    logic        drop_pending = 1'b0;
    logic [15:0] master_now = sntg_pkg::MASTER_RESET;

    square_noise_tone_generator #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_word    (in_word),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_word   (out_word),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Works out what one accepted word does to the tone queue and playback,
    // and records the sample word that a tick must produce.
    task automatic predict_word(input sntg_pkg::t_in_word w);
        sntg_pkg::t_out_word   r;
        sntg_pkg::t_tone_entry e;
        logic        positive;
        logic [31:0] mag;
        logic [47:0] prod;
        r = '0;
        if (w.action == sntg_pkg::ACT_QUEUE) begin
            // Zero-length tones are thrown away without touching the flag.
            if (w.tone_length == '0) return;
            if (pending_tones.size() >= QUEUE_DEPTH) begin
                drop_pending = 1'b1;
                return;
            end
            e.period = w.tone_period;
            e.length = w.tone_length;
            e.volume = (w.tone_volume > sntg_pkg::FULL_VOLUME) ? sntg_pkg::FULL_VOLUME
                                                                : w.tone_volume;
            pending_tones = {pending_tones, e};
            return;
        end
        // A tick with nothing playing pulls the next tone and plays its first
        // sample right away.
        if (!tone_active && pending_tones.size() != 0) begin
            e = pending_tones.pop_front();
            tone_period_now = (e.period != '0 && e.period < sntg_pkg::ONE_SAMPLE)
                              ? sntg_pkg::ONE_SAMPLE : e.period;
            tone_length_now = e.length;
            tone_pos = '0;
            phase_acc = '0;
            prod = 48'(e.volume) * 48'(master_now) * 48'(FULL_SCALE);
            tone_scale = prod[38:24];
            tone_active = 1'b1;
        end
        if (tone_active) begin
            if (tone_period_now != '0) begin
                positive = (phase_acc << 1) < 32'(tone_period_now);
                phase_acc = phase_acc + 32'(sntg_pkg::ONE_SAMPLE);
                if (phase_acc >= 32'(tone_period_now))
                    phase_acc = phase_acc - 32'(tone_period_now);
            end else begin
                noise_state = noise_state ^ (noise_state << 13);
                noise_state = noise_state ^ (noise_state >> 17);
                noise_state = noise_state ^ (noise_state << 5);
                positive = noise_state[16];
            end
            mag = (tone_pos < tone_length_now)
                ? (32'(tone_scale) * 32'(tone_length_now - tone_pos)) / 32'(tone_length_now)
                : 32'd0;
            r.sample = positive ? mag[15:0] : 16'(32'd0 - mag);
            r.playing = 1'b1;
            tone_pos = tone_pos + 16'd1;
            if (tone_pos >= tone_length_now) begin
                tone_active = 1'b0;
                r.last_sample = (pending_tones.size() == 0);
            end
        end
        // The drop flag is reported on every tick and cleared by it.
        r.tone_dropped = drop_pending;
        drop_pending = 1'b0;
        expected_words = {expected_words, r};
    endtask

    function automatic sntg_pkg::t_in_word queue_word(input logic [23:0] period,
                                                      input logic [15:0] length,
                                                      input logic [8:0] volume);
        sntg_pkg::t_in_word w;
        w.action = sntg_pkg::ACT_QUEUE;
        w.tone_period = period;
        w.tone_length = length;
        w.tone_volume = volume;
        return w;
    endfunction

    // The tone fields of a tick are don't-care, so they carry random bits.
    function automatic sntg_pkg::t_in_word tick_word();
        sntg_pkg::t_in_word w;
        w.action = sntg_pkg::ACT_TICK;
        w.tone_period = 24'($urandom);
        w.tone_length = 16'($urandom);
        w.tone_volume = 9'($urandom);
        return w;
    endfunction

    // Mostly ticks with short tones queued between them. Queueing slows down
    // once a few tones wait, yet bursts still reach a full queue now and then.
    function automatic sntg_pkg::t_in_word random_word();
        sntg_pkg::t_in_word w;
        int                 pick;
        w = tick_word();
        if ($urandom_range(99) < ((pending_tones.size() < 4) ? 30 : 8)) begin
            w.action = sntg_pkg::ACT_QUEUE;
            pick = $urandom_range(99);
            if (pick < 25)
                w.tone_period = '0;
            else if (pick < 40)
                w.tone_period = 24'($urandom_range(1, 255));
            else if (pick < 70)
                w.tone_period = 24'($urandom_range(256, 4096));
            pick = $urandom_range(99);
            if (pick < 5)
                w.tone_length = '0;
            else if (pick < 80)
                w.tone_length = 16'($urandom_range(1, 4));
            else
                w.tone_length = 16'($urandom_range(5, 32));
        end
        return w;
    endfunction

    // Offers one word, with random idle cycles ahead of it, and holds it
    // until the block takes it. Valid stays high on return so that a word
    // sent right after goes out back to back.
    task automatic send_word(input sntg_pkg::t_in_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        predict_word(w);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (expected_words.size() != 0);
    endtask

    // Writes the master level once the block has nothing left in flight.
    task automatic set_master_level(input logic [15:0] level);
        go_quiet();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        master_now = level;
    endtask

    task automatic test_idle_and_ignored();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_word(tick_word());
        send_word(queue_word(24'd256, 16'd0, 9'd256));
        send_word(tick_word());
    endtask

    // Period of two samples: the sign alternates and the last sample of the
    // tone is flagged because nothing else is queued.
    task automatic test_square_tones();
        send_word(queue_word(24'd512, 16'd3, 9'd256));
        repeat (3) send_word(tick_word());
    endtask

    task automatic test_short_period_and_noise();
        send_word(queue_word(24'd1, 16'd2, 9'h1FF));
        send_word(queue_word(24'd0, 16'd2, 9'd0));
        repeat (4) send_word(tick_word());
    endtask

    // Nine starts into eight slots; the next tick reports the lost one.
    task automatic test_queue_full();
        repeat (QUEUE_DEPTH + 1) send_word(queue_word(24'hFFFFFF, 16'd1, 9'd256));
        send_word(tick_word());
    endtask

    task automatic run_random_phase(input int count, input int send_pct,
                                    input int stall_pct, input logic [15:0] level);
        set_master_level(level);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_word(random_word());
    endtask

    // Extremes of the master level and every idling pattern.
    task automatic test_master_level_sweep();
        run_random_phase(380, 0, 0, 16'hFFFF);
        run_random_phase(380, 79, 0, 16'h0000);
        run_random_phase(380, 0, 79, 16'($urandom));
        run_random_phase(380, 22, 22, sntg_pkg::MASTER_RESET);
    endtask

    // The receiver holds off while ticks keep coming, so the block backs up
    // into its input. Then the sender waits for every result before going on.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) send_word(queue_word(24'($urandom_range(256, 2048)), 16'd4, 9'd256));
        hold_requests++;
        repeat (20) send_word(tick_word());
        go_quiet();
        wait_drained();
        repeat (20) send_word(random_word());
    endtask

    // Lengths with the top bit set. Playback is brought to idle first so the
    // longest tone really starts; it keeps playing past the end of the run.
    task automatic test_long_tone();
        send_idle_pct = 22;
        recv_stall_pct = 22;
        while (tone_active || pending_tones.size() != 0)
            send_word(tick_word());
        send_word(queue_word(24'h800000, 16'hFFFF, 9'd256));
        send_word(queue_word(24'd300, 16'h8000, 9'd128));
        repeat (12) send_word(tick_word());
    endtask

    // Receiver side: random stalls per phase, or a long counted hold-off
    // whenever a test asks for one.
    always @(posedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Every sample word taken from the block is matched against the oldest
    // prediction. All signals are sampled as they stood before the edge.
    always @(posedge clk) begin
        sntg_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            words_checked++;
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("word %0d arrived with none expected: sample %0d playing %b",
                             words_checked, $signed(out_word.sample), out_word.playing);
            end else begin
                want = expected_words.pop_front();
                if (out_word.sample !== want.sample || out_word.playing !== want.playing ||
                    out_word.last_sample !== want.last_sample ||
                    out_word.tone_dropped !== want.tone_dropped) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("word %0d: expected sample %0d play %b last %b drop %b, %s",
                                 words_checked, $signed(want.sample), want.playing,
                                 want.last_sample, want.tone_dropped,
                                 $sformatf("got sample %0d play %b last %b drop %b",
                                           $signed(out_word.sample), out_word.playing,
                                           out_word.last_sample, out_word.tone_dropped));
                end
            end
        end
    end

    // Ends a hung run: too many cycles in a row with no word moving.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_and_ignored();
        test_square_tones();
        test_short_period_and_noise();
        test_queue_full();
        test_master_level_sweep();
        test_backpressure();
        test_long_tone();
        go_quiet();
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sntg_pkg.sv
hw/rtl/sntg_mul.sv
hw/rtl/sntg_div.sv
hw/rtl/sntg_queue.sv
hw/rtl/square_noise_tone_generator.sv
hw/rtl/sntg_checker.sv
sim/tb.sv
